>>> rtl/core/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page frame allocator package
// Shared widths, codes, the range descriptor and the bit-mask helpers.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    // Bitmap geometry
    localparam int BITMAP_WORDS = 1024;
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = 5;
    localparam int ADDR_W       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int PIDX_W       = ADDR_W + BIT_W;
    localparam int CAP_INT      = BITMAP_WORDS * WORD_BITS;

    // Page numbers of 64-bit byte addresses, one extra bit for round-up
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_W       = 64 - PAGE_SHIFT + 1;
    localparam logic [PAGE_W-1:0] CAP_PAGES = PAGE_W'(CAP_INT);

    // Configuration register
    localparam int BASE_W = 20;
    localparam logic [BASE_W-1:0] BASE_RESET = 20'd2560;

    // Stream payload widths
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 56;
    localparam int IDX_W      = 10;

    // Item kinds and segment types
    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_ALLOC   = 1'b1;
    localparam logic [31:0] SEG_TYPE_RAM = 32'd1;

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(BITMAP_WORDS - 1);

    // Page range inside the bitmap: [lo, him1], empty when nothing to mark
    typedef struct packed {
        logic              empty;
        logic [PIDX_W-1:0] lo;
        logic [PIDX_W-1:0] him1;
    } rng_t;

    // Round a byte address up to a page number
    function automatic logic [PAGE_W-1:0] page_up(input logic [63:0] addr);
        page_up = {1'b0, addr[63:PAGE_SHIFT]} + PAGE_W'(|addr[PAGE_SHIFT-1:0]);
    endfunction

    // Round a byte address down to a page number
    function automatic logic [PAGE_W-1:0] page_down(input logic [63:0] addr);
        page_down = {1'b0, addr[63:PAGE_SHIFT]};
    endfunction

    // Bits bl through bh of a word set
    function automatic logic [WORD_BITS-1:0] word_mask(input logic [BIT_W-1:0] bl,
                                                       input logic [BIT_W-1:0] bh);
        word_mask = ({WORD_BITS{1'b1}} << bl) & ({WORD_BITS{1'b1}} >> (5'd31 - bh));
    endfunction

    // Position of the lowest clear bit of a word that is not full
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
        logic [WORD_BITS-1:0] onehot;
        logic [BIT_W-1:0]     idx;
        onehot = ~word & (word + 32'd1);
        idx    = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (onehot[i]) begin
                idx = idx | BIT_W'(i);
            end
        end
        lowest_zero = idx;
    endfunction

endpackage

>>> rtl/core/bpfa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// Bitmap RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bpfa_bitmap_ram import bpfa_pkg::*; (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WORD_BITS-1:0] rd_data_reg
);

    logic [WORD_BITS-1:0] mem [BITMAP_WORDS];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> rtl/core/bpfa_range.sv
// ----------------------------------------------------------------------------
// Page range clamp
// Clamps an absolute page range to the managed window and registers it.
// ----------------------------------------------------------------------------
module bpfa_range import bpfa_pkg::*; (
    input  logic              aclk,
    input  logic [PAGE_W-1:0] start_pg,
    input  logic [PAGE_W-1:0] end_pg,
    input  logic [BASE_W-1:0] base_page,
    output rng_t              rng_reg
);

    logic [PAGE_W-1:0] base_x;
    logic [PAGE_W-1:0] lo_full;
    logic [PAGE_W-1:0] hi_full;
    logic              start_lt;
    rng_t              rng_next;

    // Offset both ends from the base and clip to capacity
    always_comb begin
        base_x   = PAGE_W'(base_page);
        lo_full  = start_pg - base_x;
        hi_full  = end_pg - base_x;
        start_lt = start_pg < base_x;
        rng_next.empty = (end_pg <= base_x) || (start_pg >= end_pg) ||
                         (!start_lt && (lo_full >= CAP_PAGES));
        rng_next.lo    = start_lt ? '0 : lo_full[PIDX_W-1:0];
        rng_next.him1  = (hi_full >= CAP_PAGES) ? PIDX_W'(CAP_INT - 1)
                                                : PIDX_W'(hi_full - PAGE_W'(1));
    end

    always_ff @(posedge aclk) begin
        rng_reg <= rng_next;
    end

endmodule

>>> rtl/core/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap page frame allocator
// Marks reserved page ranges and hands out the lowest free 4 KiB frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_*: tuser selects a memory-map segment (0) or a
//   frame allocation (1). Every input word yields exactly one result word on
//   m_*. The base page register is written through cfg_*; the user must do so
//   only while idle, as the block itself does not enforce it.
// Sequence (one item at a time):
//   Segment: the gap range is clamped and each bitmap word it touches is
//   read and rewritten, and when the segment is not usable RAM its own range
//   follows the same way; the bitmap RAM does one read-modify-write a cycle.
//   Allocate: the scan starts at the lowest word that may still hold a
//   free frame; it only moves up, so skipped words cost once between resets.
// Reset:
//   A clearing pass writes every one of the 1024 bitmap words to zero, one a
//   cycle, before the first input word is taken. Configuration writes are
//   taken during the pass.
// Stalls:
//   The result sits in an output register; the next input word is taken
//   while it waits, and work stops only when a new result is ready while the old one still waits.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator import bpfa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // kind
    input  logic [0:0]            s_tuser,
    // seg_base, seg_length, seg_type, vaddr
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ok
    output logic [0:0]            m_tuser,
    // frame_addr, dir_index, table_index, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // reserved_base_page
    input  logic [BASE_W-1:0]     cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_RANGE   = 7'b0000100,
        ST_MARK_RD = 7'b0001000,
        ST_MARK    = 7'b0010000,
        ST_ALLOC   = 7'b0100000,
        ST_RESULT  = 7'b1000000
    } state_t;

    // Control state
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0] hint_reg, hint_next;
    logic [63:0]       prev_end_reg, prev_end_next;
    logic [BASE_W-1:0] base_page_reg, base_page_next;
    logic              own_pending_reg, own_pending_next;
    logic              out_valid_reg, out_valid_next;

    // Payload
    logic [PAGE_W-1:0]     start_pg_reg, start_pg_next;
    logic [PAGE_W-1:0]     end_pg_reg, end_pg_next;
    logic [63:0]           seg_base_reg, seg_base_next;
    logic [63:0]           seg_end_reg, seg_end_next;
    logic [ADDR_W-1:0]     w_reg, w_next;
    logic                  res_ok_reg, res_ok_next;
    logic [31:0]           res_frame_reg, res_frame_next;
    logic [IDX_W-1:0]      res_dir_reg, res_dir_next;
    logic [IDX_W-1:0]      res_tab_reg, res_tab_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_ok_reg, out_ok_next;

    // RAM and range unit hookup
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    rng_t                 rng;

    // Input fields
    logic        in_kind;
    logic [63:0] in_seg_base;
    logic [63:0] in_seg_length;
    logic [31:0] in_seg_type;
    logic [31:0] in_vaddr;

    // Mark and allocate helpers
    logic [ADDR_W-1:0] lo_w, hi_w;
    logic [BIT_W-1:0]  bl, bh;
    logic [BIT_W-1:0]  free_bit;
    logic [BASE_W-1:0] frame_page;
    logic              in_fire;

    assign in_kind       = s_tuser[0];
    assign in_seg_base   = s_tdata[63:0];
    assign in_seg_length = s_tdata[127:64];
    assign in_seg_type   = s_tdata[159:128];
    assign in_vaddr      = s_tdata[191:160];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_ok_reg;
    assign in_fire   = s_tvalid && s_tready;

    assign lo_w       = rng.lo[PIDX_W-1:BIT_W];
    assign hi_w       = rng.him1[PIDX_W-1:BIT_W];
    assign bl         = (w_reg == lo_w) ? rng.lo[BIT_W-1:0] : '0;
    assign bh         = (w_reg == hi_w) ? rng.him1[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);
    assign free_bit   = lowest_zero(rd_data);
    assign frame_page = base_page_reg + BASE_W'({hint_reg, free_bit});

    bpfa_bitmap_ram u_ram (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data)
    );

    bpfa_range u_range (
        .aclk      (aclk),
        .start_pg  (start_pg_reg),
        .end_pg    (end_pg_reg),
        .base_page (base_page_reg),
        .rng_reg   (rng)
    );

    // Sequencer: clear, mark ranges, scan for a free frame, push result
    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        hint_next        = hint_reg;
        prev_end_next    = prev_end_reg;
        base_page_next   = base_page_reg;
        own_pending_next = own_pending_reg;
        out_valid_next   = out_valid_reg;
        start_pg_next    = start_pg_reg;
        end_pg_next      = end_pg_reg;
        seg_base_next    = seg_base_reg;
        seg_end_next     = seg_end_reg;
        w_next           = w_reg;
        res_ok_next      = res_ok_reg;
        res_frame_next   = res_frame_reg;
        res_dir_next     = res_dir_reg;
        res_tab_next     = res_tab_reg;
        out_data_next    = out_data_reg;
        out_ok_next      = out_ok_reg;
        wr_en            = 1'b0;
        wr_addr          = w_reg;
        wr_data          = rd_data;
        rd_addr          = hint_reg;

        // Drop the result once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        // Take the base page register
        if (cfg_valid) begin
            base_page_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                if (clr_cnt_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    res_ok_next    = 1'b1;
                    res_frame_next = '0;
                    if (in_kind == KIND_SEGMENT) begin
                        res_dir_next     = '0;
                        res_tab_next     = '0;
                        start_pg_next    = page_down(prev_end_reg);
                        end_pg_next      = page_up(in_seg_base);
                        seg_base_next    = in_seg_base;
                        seg_end_next     = in_seg_base + in_seg_length;
                        prev_end_next    = in_seg_base + in_seg_length;
                        own_pending_next = (in_seg_type != SEG_TYPE_RAM);
                        state_next       = ST_RANGE;
                    end else begin
                        res_dir_next = in_vaddr[31:22];
                        res_tab_next = in_vaddr[21:12];
                        rd_addr      = hint_reg;
                        state_next   = ST_ALLOC;
                    end
                end
            end
            ST_RANGE: begin
                // Range unit registers the clamped range this cycle
                state_next = ST_MARK_RD;
            end
            ST_MARK_RD: begin
                if (rng.empty) begin
                    if (own_pending_reg) begin
                        start_pg_next    = page_down(seg_base_reg);
                        end_pg_next      = page_up(seg_end_reg);
                        own_pending_next = 1'b0;
                        state_next       = ST_RANGE;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else begin
                    rd_addr    = lo_w;
                    w_next     = lo_w;
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                // Set the range bits in the word read last cycle
                wr_en   = 1'b1;
                wr_addr = w_reg;
                wr_data = rd_data | word_mask(bl, bh);
                if (w_reg == hi_w) begin
                    if (own_pending_reg) begin
                        start_pg_next    = page_down(seg_base_reg);
                        end_pg_next      = page_up(seg_end_reg);
                        own_pending_next = 1'b0;
                        state_next       = ST_RANGE;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else begin
                    rd_addr = w_reg + ADDR_W'(1);
                    w_next  = w_reg + ADDR_W'(1);
                end
            end
            ST_ALLOC: begin
                if (rd_data != {WORD_BITS{1'b1}}) begin
                    wr_en          = 1'b1;
                    wr_addr        = hint_reg;
                    wr_data        = rd_data | (WORD_BITS'(1) << free_bit);
                    res_ok_next    = 1'b1;
                    res_frame_next = {frame_page, 12'd0};
                    state_next     = ST_RESULT;
                end else if (hint_reg == LAST_WORD) begin
                    res_ok_next    = 1'b0;
                    res_frame_next = '0;
                    state_next     = ST_RESULT;
                end else begin
                    // Word full: advance the scan and the low-water mark
                    hint_next = hint_reg + ADDR_W'(1);
                    rd_addr   = hint_reg + ADDR_W'(1);
                end
            end
            ST_RESULT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_data_next  = {4'd0, res_tab_reg, res_dir_reg, res_frame_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            hint_reg        <= '0;
            prev_end_reg    <= '0;
            base_page_reg   <= BASE_RESET;
            own_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            hint_reg        <= hint_next;
            prev_end_reg    <= prev_end_next;
            base_page_reg   <= base_page_next;
            own_pending_reg <= own_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        start_pg_reg  <= start_pg_next;
        end_pg_reg    <= end_pg_next;
        seg_base_reg  <= seg_base_next;
        seg_end_reg   <= seg_end_next;
        w_reg         <= w_next;
        res_ok_reg    <= res_ok_next;
        res_frame_reg <= res_frame_next;
        res_dir_reg   <= res_dir_next;
        res_tab_reg   <= res_tab_next;
        out_data_reg  <= out_data_next;
        out_ok_reg    <= out_ok_next;
    end

`ifndef ASSERT_OFF
    // No input word is taken while the bitmap is being cleared
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input taken during clearing pass");

    // The scan start only moves up between resets
    a_hint_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (hint_reg >= $past(hint_reg)))
        else $error("allocation scan start moved down");

    // A successful allocation sets exactly one new bit
    a_alloc_one_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_ALLOC) && wr_en) |-> ($countones(wr_data ^ rd_data) == 1))
        else $error("allocation changed other than one bit");

    // The bitmap is never written while idle
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("bitmap written while idle");
`endif

endmodule
